// File: rtl/assert_macros.svh
// Assertion macros shared by the digit generator and the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/itf_pkg.sv
// Shared constants, types and functions for the integer-to-text field core.
package itf_pkg;

  localparam int MAX_WIDTH_DEF = 16;
  localparam int VALUE_W       = 32;
  localparam int FW_W          = 5;
  localparam int OP_W          = 2;
  localparam int CHAR_W        = 7;

  // Format codes; the high bit selects hex, so code three also acts as hex.
  localparam logic [OP_W-1:0] OP_UDEC    = 2'd0;
  localparam logic [OP_W-1:0] OP_SDEC    = 2'd1;
  localparam logic [OP_W-1:0] OP_HEX     = 2'd2;
  localparam logic [OP_W-1:0] OP_HEX_ALT = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

  // ceil(2^35 / 10): floor(x * RECIP10 / 2^35) == x / 10 for all 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP10_SHIFT = 35;

  typedef struct packed {
    logic load;       // take a new operand
    logic step;       // emit one character, right to left
    logic last_slot;  // current position is field position 0
  } itf_gen_ctl_t;

  typedef struct packed {
    logic push;  // shift toward the right end, new char enters cell 0
    logic pop;   // shift toward cell 0
  } itf_cell_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// File: rtl/itf_cell.sv
// One character cell of the field shift chain.
module itf_cell (
  input  logic                         clk,
  input  itf_pkg::itf_cell_ctl_t       ctl,
  input  logic [itf_pkg::CHAR_W-1:0]   left_char,
  input  logic [itf_pkg::CHAR_W-1:0]   right_char,
  output logic [itf_pkg::CHAR_W-1:0]   char_q
);

  logic [itf_pkg::CHAR_W-1:0] char_r;
  logic [itf_pkg::CHAR_W-1:0] char_nxt;

  always_comb begin
    priority if (ctl.push) begin
      char_nxt = left_char;
    end else if (ctl.pop) begin
      char_nxt = right_char;
    end else begin
      char_nxt = char_r;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

// File: rtl/itf_digit_gen.sv
// Digit generator: one character per step, rightmost first.
module itf_digit_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itf_pkg::itf_gen_ctl_t         ctl,
  input  logic [itf_pkg::VALUE_W-1:0]   value,
  input  logic [itf_pkg::OP_W-1:0]      opcode,
  output logic [itf_pkg::CHAR_W-1:0]    gen_char
);

  localparam int QW = 2 * itf_pkg::VALUE_W - itf_pkg::RECIP10_SHIFT;

  logic [itf_pkg::VALUE_W-1:0] mag_r, mag_nxt;
  logic                        hex_r, sgn_r, first_r, sign_pend_r;

  logic [2*itf_pkg::VALUE_W-1:0] prod;
  logic [QW-1:0]                 quot;
  logic [3:0]                    prod10_lo, rem10, digit;
  logic                          digit_now;
  logic                          ld_hex, ld_sgn, ld_neg;

  assign ld_hex = (opcode == itf_pkg::OP_HEX) || (opcode == itf_pkg::OP_HEX_ALT);
  assign ld_sgn = (opcode == itf_pkg::OP_SDEC);
  assign ld_neg = ld_sgn && value[itf_pkg::VALUE_W-1];

  // divide by ten via reciprocal; remainder from the low nibble only
  assign prod      = {{itf_pkg::VALUE_W{1'b0}}, mag_r} *
                     {{itf_pkg::VALUE_W{1'b0}}, itf_pkg::RECIP10};
  assign quot      = prod[2*itf_pkg::VALUE_W-1:itf_pkg::RECIP10_SHIFT];
  assign prod10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign rem10     = mag_r[3:0] - prod10_lo;

  assign digit     = hex_r ? mag_r[3:0] : rem10;
  // sign position stays free in signed mode, unless it takes the first digit
  assign digit_now = first_r || ((mag_r != '0) && !(sgn_r && ctl.last_slot));

  always_comb begin
    if (digit_now) begin
      gen_char = itf_pkg::digit_char(digit);
    end else if (sign_pend_r) begin
      gen_char = itf_pkg::CH_MINUS;
    end else begin
      gen_char = itf_pkg::CH_SPACE;
    end
  end

  always_comb begin
    priority if (ctl.load) begin
      mag_nxt = ld_neg ? ('0 - value) : value;
    end else if (ctl.step && digit_now) begin
      mag_nxt = hex_r ? {4'b0000, mag_r[itf_pkg::VALUE_W-1:4]}
                      : itf_pkg::VALUE_W'(quot);
    end else begin
      mag_nxt = mag_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    if (!rst_n) begin
      first_r     <= 1'b0;
      sign_pend_r <= 1'b0;
      hex_r       <= 1'b0;
      sgn_r       <= 1'b0;
    end else if (ctl.load) begin
      first_r     <= 1'b1;
      sign_pend_r <= ld_neg;
      hex_r       <= ld_hex;
      sgn_r       <= ld_sgn;
    end else if (ctl.step) begin
      first_r <= 1'b0;
      if (!digit_now) begin
        sign_pend_r <= 1'b0;
      end
    end
  end

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_first_digit, ctl.load, first_r, "first step must emit a digit")
  `ASSERT_NEXT(a_sign_once, ctl.step && !digit_now && sign_pend_r, !sign_pend_r, "minus emitted twice")

endmodule

// File: rtl/integer_to_text_field_core.sv
// Top level: integer to right-justified text field converter.
//
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  input   | in_valid/in_ready, in_value, in_field_width, in_opcode | in
//  result  | out_valid/out_ready, out_text_char, out_last | out
//
// One word in, field_width words out (width 0 reads as 1, above MAX_WIDTH
// saturates). Per word: the accept, a conversion pass in S_CONV (one
// character per cycle through the digit generator), then an output pass in
// S_EMIT shifting the cell chain toward cell 0 on each accepted character.
// One word is worked on at a time; in_ready is low from accept until the
// last character is taken. Output stalls hold the chain. Synchronous
// active-low reset returns to idle; the chain needs none.
module integer_to_text_field_core #(
  parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itf_pkg::VALUE_W-1:0]   in_value,
  input  logic [itf_pkg::FW_W-1:0]      in_field_width,
  input  logic [itf_pkg::OP_W-1:0]      in_opcode,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itf_pkg::CHAR_W-1:0]    out_text_char,
  output logic                          out_last
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > itf_pkg::FW_W) ? CW : itf_pkg::FW_W;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t        state_r;
  logic [CW-1:0] rem_r;   // characters left in the current pass
  logic [CW-1:0] w_r;     // clamped field width

  logic [WW-1:0] fw_ext;
  logic [CW-1:0] w_clamp;
  logic          in_acc, out_acc;

  itf_pkg::itf_gen_ctl_t  gen_ctl;
  itf_pkg::itf_cell_ctl_t cell_ctl;
  logic [itf_pkg::CHAR_W-1:0] gen_char;
  logic [itf_pkg::CHAR_W-1:0] chain [MAX_WIDTH];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign fw_ext = WW'(in_field_width);
  always_comb begin
    if (fw_ext == '0) begin
      w_clamp = CW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = CW'(fw_ext);
    end
  end

  assign gen_ctl.load      = in_acc;
  assign gen_ctl.step      = (state_r == S_CONV);
  assign gen_ctl.last_slot = (rem_r == CW'(1));

  assign cell_ctl.push = (state_r == S_CONV);
  assign cell_ctl.pop  = out_acc;

  itf_digit_gen u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (gen_ctl),
    .value    (in_value),
    .opcode   (in_opcode),
    .gen_char (gen_char)
  );

  // Cell 0 holds the leftmost character once conversion finishes.
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [itf_pkg::CHAR_W-1:0] left_c, right_c;
    if (i == 0) begin : g_head
      assign left_c = gen_char;
    end else begin : g_body
      assign left_c = chain[i-1];
    end
    if (i == MAX_WIDTH - 1) begin : g_tail
      assign right_c = itf_pkg::CH_SPACE;
    end else begin : g_inner
      assign right_c = chain[i+1];
    end
    itf_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .left_char  (left_c),
      .right_char (right_c),
      .char_q     (chain[i])
    );
  end

  assign out_text_char = chain[0];
  assign out_last      = (rem_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rem_r   <= '0;
      w_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            w_r     <= w_clamp;
            rem_r   <= w_clamp;
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          if (rem_r == CW'(1)) begin
            rem_r   <= w_r;
            state_r <= S_EMIT;
          end else begin
            rem_r <= rem_r - CW'(1);
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (rem_r == CW'(1)) begin
              state_r <= S_IDLE;
            end else begin
              rem_r <= rem_r - CW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_ON(a_one_side, !(in_ready && out_valid), "input and output active together")
  `ASSERT_NEXT(a_busy_after_acc, in_acc, !in_ready, "accepted a second word while busy")
  `ASSERT_NEXT(a_idle_after_last, out_acc && out_last, in_ready, "no return to idle after last")
  `ASSERT_ON(a_emit_count, !$rose(out_valid) || (rem_r == w_r), "emit pass starts mid-field")

endmodule

// File: test/testbench.sv
// Self-checking testbench for integer_to_text_field_core: directed table, then random words.
`timescale 1ns / 1ps

module testbench;

  localparam int FIELD_MAX   = itf_pkg::MAX_WIDTH_DEF;
  localparam int RANDOM_WORDS = 350;
  // Slowest legal word is a full-width conversion plus 16 chars, each behind a random output stall,
  // plus a random input gap; the limit is set well above that for every word.
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam int N_DIR       = 24;

  // One character of a field as it leaves the result channel.
  typedef struct packed {
    logic [itf_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } char_word_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [itf_pkg::VALUE_W-1:0] in_value;
  logic [itf_pkg::FW_W-1:0]    in_field_width;
  logic [itf_pkg::OP_W-1:0]    in_opcode;
  logic                        out_valid;
  logic                        out_ready;
  logic [itf_pkg::CHAR_W-1:0]  out_text_char;
  logic                        out_last;

  // Characters still owed by the block, oldest first.
  char_word_t  pending_chars[$];
  int unsigned mismatches;
  // While set, neither side inserts idle cycles.
  bit          no_idle;

  integer_to_text_field_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_opcode      (in_opcode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_text_char  (out_text_char),
    .out_last       (out_last)
  );

  // Directed table. A non-empty text is the field as typed by hand; an empty one
  // means the expected characters come from the field formatter below.
  logic [itf_pkg::VALUE_W-1:0] dir_value [N_DIR] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd12345,
    32'h0000_ABCD, 32'hFFFF_FFF9, 32'd123456,    32'hFFFE_1DC0,
    32'h1234_5678, 32'h9ABC_DEF0, 32'h8000_0000, 32'h8000_0000,
    32'h0000_0001, 32'hFFFF_FC18, 32'h0000_0005, 32'hFFFF_FFFB
  };
  logic [itf_pkg::FW_W-1:0] dir_width [N_DIR] = '{
    5'd4,  5'd10, 5'd16, 5'd12,
    5'd16, 5'd5,  5'd8,  5'd4,
    5'd0,  5'd3,  5'd1,  5'd31,
    5'd6,  5'd1,  5'd3,  5'd4,
    5'd10, 5'd16, 5'd11, 5'd16,
    5'd17, 5'd20, 5'd2,  5'd2
  };
  logic [itf_pkg::OP_W-1:0] dir_op [N_DIR] = '{
    itf_pkg::OP_UDEC,    itf_pkg::OP_UDEC,    itf_pkg::OP_UDEC, itf_pkg::OP_SDEC,
    itf_pkg::OP_SDEC,    itf_pkg::OP_SDEC,    itf_pkg::OP_HEX,  itf_pkg::OP_HEX,
    itf_pkg::OP_UDEC,    itf_pkg::OP_SDEC,    itf_pkg::OP_HEX,  itf_pkg::OP_UDEC,
    itf_pkg::OP_HEX_ALT, itf_pkg::OP_SDEC,    itf_pkg::OP_UDEC, itf_pkg::OP_SDEC,
    itf_pkg::OP_UDEC,    itf_pkg::OP_HEX,     itf_pkg::OP_SDEC, itf_pkg::OP_UDEC,
    itf_pkg::OP_SDEC,    itf_pkg::OP_HEX_ALT, itf_pkg::OP_SDEC, itf_pkg::OP_SDEC
  };
  string dir_text [N_DIR] = '{
    "   0",                 // zero: lone digit at the right end
    "4294967295",           // all ones, exact fit
    "      4294967295",     // all ones, full width
    " -2147483648",         // most negative, magnitude taken unsigned
    "      2147483647",     // most positive signed
    "   -1",                // minus one
    "FFFFFFFF",             // hex all ones
    "FFFF",                 // hex overflow keeps low digits
    "0",                    // zero width reads as one
    "  0",                  // signed zero
    "0",                    // hex zero, width one
    "           12345",     // width above max saturates
    "  ABCD",               // opcode three acts as hex
    "7",                    // signed width one drops the sign
    "456",                  // decimal overflow
    "-456",                 // sign lands in reserved slot after truncation
    "", "", "", "", "", "", "",
    "-5"                    // sign just left of a single digit
  };

  // Field formatter: spaces, then digits right to left, then the sign.
  function automatic void format_field(input logic [itf_pkg::VALUE_W-1:0] value,
                                       input logic [itf_pkg::FW_W-1:0]    width_code,
                                       input logic [itf_pkg::OP_W-1:0]    op);
    logic [itf_pkg::CHAR_W-1:0]  cells [FIELD_MAX];
    logic [itf_pkg::VALUE_W-1:0] mag;
    logic [3:0]                  digit;
    logic                        hex_fmt;
    logic                        signed_fmt;
    logic                        negative;
    int                          width;
    int                          pos;
    int                          low_pos;
    char_word_t                  cw;

    if (width_code == 0) begin
      width = 1;
    end else if (width_code > FIELD_MAX) begin
      width = FIELD_MAX;
    end else begin
      width = width_code;
    end
    hex_fmt    = op[1];
    signed_fmt = (op == itf_pkg::OP_SDEC);
    low_pos    = signed_fmt ? 1 : 0;   // signed keeps position 0 for the sign
    negative   = signed_fmt && value[itf_pkg::VALUE_W-1];
    mag        = negative ? (32'd0 - value) : value;

    for (int k = 0; k < FIELD_MAX; k++) cells[k] = itf_pkg::CH_SPACE;

    pos = width - 1;
    do begin
      if (hex_fmt) begin
        digit = mag[3:0];
        mag   = mag >> 4;
      end else begin
        digit = 4'(mag % 32'd10);
        mag   = mag / 32'd10;
      end
      cells[pos] = (digit < 4'd10)
                   ? (itf_pkg::CH_ZERO + itf_pkg::CHAR_W'(digit))
                   : (itf_pkg::CH_A + itf_pkg::CHAR_W'(digit - 4'd10));
      pos--;
    end while (mag != 0 && pos >= low_pos);

    if (negative && pos >= 0) cells[pos] = itf_pkg::CH_MINUS;

    for (int k = 0; k < width; k++) begin
      cw.ch   = cells[k];
      cw.last = (k == width - 1);
      pending_chars.push_back(cw);
    end
  endfunction

  // Hand-typed field: last flag on its final character.
  function automatic void expect_text(input string text);
    char_word_t cw;
    for (int k = 0; k < text.len(); k++) begin
      cw.ch   = itf_pkg::CHAR_W'(text[k]);
      cw.last = (k == text.len() - 1);
      pending_chars.push_back(cw);
    end
  endfunction

  // Offer one word; returns at the edge where it is taken, with its
  // expected characters queued.
  task automatic send_word(input logic [itf_pkg::VALUE_W-1:0] value,
                           input logic [itf_pkg::FW_W-1:0]    width_code,
                           input logic [itf_pkg::OP_W-1:0]    op,
                           input string                       text);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_value       <= value;
    in_field_width <= width_code;
    in_opcode      <= op;
    do @(posedge clk); while (!in_ready);
    if (text.len() != 0) begin
      expect_text(text);
    end else begin
      format_field(value, width_code, op);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on cycle count.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: random stall before each character, then take and check it.
  initial begin : result_side
    int         stall;
    char_word_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected char word 0x%02h last=%0b", $realtime,
                   out_text_char, out_last);
      end else begin
        want = pending_chars.pop_front();
        if (out_text_char !== want.ch || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: char 0x%02h last=%0b, expected 0x%02h last=%0b",
                     $realtime, out_text_char, out_last, want.ch, want.last);
        end
      end
    end
  end

  // Input side: reset, directed table, random words, drain.
  initial begin : input_side
    logic [itf_pkg::VALUE_W-1:0] value;
    logic [itf_pkg::FW_W-1:0]    width_code;
    logic [itf_pkg::OP_W-1:0]    op;
    mismatches     = 0;
    no_idle        = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_field_width <= '0;
    in_opcode      <= itf_pkg::OP_UDEC;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_word(dir_value[i], dir_width[i], dir_op[i], dir_text[i]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Every so often run a stretch with both sides at full rate.
      if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 4))
        0: value = $urandom();
        1: value = $urandom_range(0, 999);
        2: value = 32'd0 - $urandom_range(1, 99999);    // small negatives
        3: value = $urandom() >> $urandom_range(0, 31);  // spread digit counts
        default: value = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom())};
      endcase

      // Mostly legal widths; now and then zero or above the max.
      if ($urandom_range(0, 9) != 0) begin
        width_code = itf_pkg::FW_W'($urandom_range(1, FIELD_MAX));
      end else begin
        width_code = $urandom_range(0, 1) ? 5'd0
                                          : itf_pkg::FW_W'($urandom_range(FIELD_MAX + 1, 31));
      end

      op = ($urandom_range(0, 7) == 0) ? itf_pkg::OP_HEX_ALT
                                       : itf_pkg::OP_W'($urandom_range(0, 2));
      send_word(value, width_code, op, "");
    end

    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/itf_pkg.sv
rtl/itf_cell.sv
rtl/itf_digit_gen.sv
rtl/integer_to_text_field_core.sv
test/testbench.sv
